// ===== src/marching_tetrahedra_cell_assert.svh =====
// Assertion macros shared by the marching tetrahedra cell RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef MARCHING_TETRAHEDRA_CELL_ASSERT_SVH
`define MARCHING_TETRAHEDRA_CELL_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define MTC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define MTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define MTC_ASSERT_IMPLIES(label, ante, cons)
`define MTC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/mtc_pkg.sv =====
// Package for the marching tetrahedra cell: default sizes and the lookup tables.
// Used by every module of the block; depends on nothing.
package mtc_pkg;

    localparam int GRID_BITS_DEF   = 10;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int CFG_BITS        = 16;
    localparam int NUM_TETRA       = 6;
    localparam int NUM_SLOTS       = 2 * NUM_TETRA;
    localparam int SLOT_IDX_BITS   = 4;

    typedef logic [2:0] t_corner;
    typedef logic [3:0] t_mask;
    typedef logic [3:0] t_edge;            // {local a, local b}
    typedef logic [2:0][3:0] t_tri_edges;  // [vertex]
    typedef logic [1:0][2:0][3:0] t_case;  // [triangle][vertex]

    // Cube corner of local vertex i of tetrahedron k.
    function automatic t_corner tetra_corner(input logic [2:0] k, input logic [1:0] i);
        logic [3:0][2:0] row;
        begin
            case (k)
                3'd0:    row = {3'd2, 3'd3, 3'd7, 3'd0};
                3'd1:    row = {3'd6, 3'd2, 3'd7, 3'd0};
                3'd2:    row = {3'd6, 3'd7, 3'd4, 3'd0};
                3'd3:    row = {3'd2, 3'd6, 3'd1, 3'd0};
                3'd4:    row = {3'd1, 3'd6, 3'd4, 3'd0};
                3'd5:    row = {3'd4, 3'd6, 3'd1, 3'd5};
                default: row = '0;
            endcase
            return row[i];
        end
    endfunction

    // Corner offsets along each axis: {dz, dy, dx}.
    function automatic logic [2:0] corner_delta(input t_corner c);
        return {c[2], c[1], c[0] ^ c[1]};
    endfunction

    // Number of triangles a tetrahedron mask produces.
    function automatic logic [1:0] case_count(input t_mask m);
        logic [2:0] ones;
        begin
            ones = 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
            if (ones == 3'd0 || ones == 3'd4) begin
                return 2'd0;
            end else if (ones == 3'd2) begin
                return 2'd2;
            end else begin
                return 2'd1;
            end
        end
    endfunction

    function automatic t_tri_edges mk_tri(input logic [1:0] a0, input logic [1:0] b0,
                                          input logic [1:0] a1, input logic [1:0] b1,
                                          input logic [1:0] a2, input logic [1:0] b2);
        return {a2, b2, a1, b1, a0, b0};
    endfunction

    // Edges crossed by each triangle of a case, in vertex order.
    function automatic t_case case_edges(input t_mask m);
        t_tri_edges t0;
        t_tri_edges t1;
        begin
            t0 = '0;
            t1 = '0;
            case (m)
                4'd1:  t0 = mk_tri(2'd0, 2'd1, 2'd0, 2'd3, 2'd0, 2'd2);
                4'd2:  t0 = mk_tri(2'd1, 2'd0, 2'd1, 2'd2, 2'd1, 2'd3);
                4'd3: begin
                    t0 = mk_tri(2'd3, 2'd0, 2'd2, 2'd0, 2'd1, 2'd3);
                    t1 = mk_tri(2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd3);
                end
                4'd4:  t0 = mk_tri(2'd2, 2'd0, 2'd2, 2'd3, 2'd2, 2'd1);
                4'd5: begin
                    t0 = mk_tri(2'd3, 2'd0, 2'd1, 2'd2, 2'd1, 2'd0);
                    t1 = mk_tri(2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd3);
                end
                4'd6: begin
                    t0 = mk_tri(2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd3);
                    t1 = mk_tri(2'd1, 2'd3, 2'd0, 2'd2, 2'd3, 2'd2);
                end
                4'd7:  t0 = mk_tri(2'd3, 2'd0, 2'd3, 2'd2, 2'd3, 2'd1);
                4'd8:  t0 = mk_tri(2'd3, 2'd1, 2'd3, 2'd2, 2'd3, 2'd0);
                4'd9: begin
                    t0 = mk_tri(2'd0, 2'd1, 2'd1, 2'd3, 2'd0, 2'd2);
                    t1 = mk_tri(2'd1, 2'd3, 2'd3, 2'd2, 2'd0, 2'd2);
                end
                4'd10: begin
                    t0 = mk_tri(2'd3, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2);
                    t1 = mk_tri(2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0);
                end
                4'd11: t0 = mk_tri(2'd2, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0);
                4'd12: begin
                    t0 = mk_tri(2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd0);
                    t1 = mk_tri(2'd2, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1);
                end
                4'd13: t0 = mk_tri(2'd1, 2'd0, 2'd1, 2'd3, 2'd1, 2'd2);
                4'd14: t0 = mk_tri(2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3);
                default: begin
                    t0 = '0;
                    t1 = '0;
                end
            endcase
            return {t1, t0};
        end
    endfunction

endpackage

// ===== src/marching_tetrahedra_cell.sv =====
// Marching tetrahedra cell: triangles of the iso surface for one cube cell.
// Channels: the slave stream takes one cell per transaction (base coordinate
// and eight corner samples in tdata); the master stream gives one triangle
// per transaction (nine vertex coordinates in tdata, tlast on the cell's last
// triangle). A cell with no crossing gives no transaction. The threshold is
// written through i_cfg_wr_en / i_cfg_wr_data; the user must do so only while
// the block is idle, the block does not enforce it. Throughput: one triangle
// per cycle while the receiver takes them, from the issue stage handing out
// one triangle slot a cycle. A cell passes the cell register, the issue stage,
// the bit-per-stage divider pipelines of the three vertex lanes and the output
// register. Reset clears all valid flags and sets the threshold to zero.
// When the receiver stalls the whole pipeline holds; the output register
// keeps its triangle and the slave side stops taking cells.
// Depends on mtc_pkg, mtc_tetra_lane, mtc_div_pipe and the assertion header.
`include "marching_tetrahedra_cell_assert.svh"
module marching_tetrahedra_cell #(
    parameter int GRID_BITS   = mtc_pkg::GRID_BITS_DEF,
    parameter int SAMPLE_BITS = mtc_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = mtc_pkg::FRAC_BITS_DEF,
    localparam int IN_W   = 3 * GRID_BITS + 8 * SAMPLE_BITS,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OW     = GRID_BITS + FRAC_BITS,
    localparam int OUT_W  = 9 * OW,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [mtc_pkg::CFG_BITS-1:0]   i_cfg_wr_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // base_x, base_y, base_z, sample_c0 .. sample_c7 from bit 0 up
    input  logic [IN_TW-1:0]               i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // vert_a_x/y/z, vert_b_x/y/z, vert_c_x/y/z from bit 0 up
    output logic [OUT_TW-1:0]              o_m_tdata,
    output logic                           o_m_tlast
);

    localparam int NS   = mtc_pkg::NUM_SLOTS;
    localparam int SD_W = 6;
    localparam int S0_W = SD_W + 3 * GRID_BITS + 1;

    logic [SAMPLE_BITS-1:0] r_iso;
    logic                   w_en;
    logic                   w_s_acc;

    logic [7:0][SAMPLE_BITS-1:0]   w_in_samp;
    logic [5:0][3:0]               w_in_mask;
    logic [NS-1:0]                 w_in_slots;

    logic [NS-1:0]                 r_slots;
    logic [7:0][SAMPLE_BITS-1:0]   r_samp;
    logic [5:0][3:0]               r_mask;
    logic [3*GRID_BITS-1:0]        r_base;

    logic [NS-1:0]                 w_pick_oh;
    logic [NS-1:0]                 w_remain;
    logic [mtc_pkg::SLOT_IDX_BITS-1:0] w_pick;
    logic                          w_issue;
    mtc_pkg::t_case                w_case;
    logic [2:0]                    w_k;

    logic                          r_a_vld;
    logic [2:0][SAMPLE_BITS-1:0]   r_a_va;
    logic [2:0][SAMPLE_BITS-1:0]   r_a_vb;
    logic [2:0][SD_W-1:0]          r_a_dir;
    logic [3*GRID_BITS-1:0]        r_a_base;
    logic                          r_a_last;

    logic [2:0]                    w_d_vld;
    logic [2:0][FRAC_BITS:0]       w_d_q;
    logic [S0_W-1:0]               w_side0;
    logic [1:0][SD_W-1:0]          w_side12;
    logic [2:0][SD_W-1:0]          w_d_dir;
    logic [3*GRID_BITS-1:0]        w_d_base;
    logic [OUT_W-1:0]              n_out;

    logic                          r_out_vld;
    logic [OUT_W-1:0]              r_out;
    logic                          r_out_last;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso <= '0;
        end else if (i_cfg_wr_en) begin
            r_iso <= SAMPLE_BITS'(i_cfg_wr_data);
        end
    end

    // The pipeline moves whenever the output register can take a triangle.
    assign w_en    = !r_out_vld || i_m_tready;
    assign w_remain = r_slots & (r_slots - NS'(1));
    assign o_s_tready = w_en && (w_remain == '0);
    assign w_s_acc = i_s_tvalid && o_s_tready;
    assign w_issue = r_slots != '0;

    // Unpack the cell and run the six tetrahedron lanes on it.
    for (genvar c = 0; c < 8; c++) begin : g_samp
        assign w_in_samp[c] = i_s_tdata[3*GRID_BITS + c*SAMPLE_BITS +: SAMPLE_BITS];
    end
    for (genvar k = 0; k < 6; k++) begin : g_lane
        logic [3:0][SAMPLE_BITS-1:0] w_ls;
        for (genvar i = 0; i < 4; i++) begin : g_v
            assign w_ls[i] = w_in_samp[mtc_pkg::tetra_corner(3'(k), 2'(i))];
        end
        mtc_tetra_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .i_samp (w_ls),
            .i_iso  (r_iso),
            .o_mask (w_in_mask[k]),
            .o_slots(w_in_slots[2*k +: 2])
        );
    end

    // Cell register: holds the slots still to be issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
        end else if (w_s_acc) begin
            r_slots <= w_in_slots;
        end else if (w_en) begin
            r_slots <= w_remain;
        end
        if (w_s_acc) begin
            r_samp <= w_in_samp;
            r_mask <= w_in_mask;
            r_base <= i_s_tdata[3*GRID_BITS-1:0];
        end
    end

    // Merge: lowest pending slot goes first.
    assign w_pick_oh = r_slots & (~r_slots + NS'(1));
    always_comb begin
        w_pick = '0;
        for (int s = 0; s < NS; s++) begin
            if (w_pick_oh[s]) begin
                w_pick = mtc_pkg::SLOT_IDX_BITS'(s);
            end
        end
    end
    assign w_k    = w_pick[3:1];
    assign w_case = mtc_pkg::case_edges(r_mask[w_k]);

    // Issue stage: endpoints of the three crossing edges.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= w_issue;
        end
        if (w_en) begin
            for (int v = 0; v < 3; v++) begin
                r_a_va[v]  <= r_samp[mtc_pkg::tetra_corner(w_k, w_case[w_pick[0]][v][3:2])];
                r_a_vb[v]  <= r_samp[mtc_pkg::tetra_corner(w_k, w_case[w_pick[0]][v][1:0])];
                r_a_dir[v] <= {
                    mtc_pkg::corner_delta(mtc_pkg::tetra_corner(w_k, w_case[w_pick[0]][v][1:0])),
                    mtc_pkg::corner_delta(mtc_pkg::tetra_corner(w_k, w_case[w_pick[0]][v][3:2]))
                };
            end
            r_a_base <= r_base;
            r_a_last <= w_remain == '0;
        end
    end

    // Vertex lanes: one divider pipeline per triangle corner.
    mtc_div_pipe #(
        .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS), .SIDE_W(S0_W)
    ) u_div0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_a_vld),
        .i_va(r_a_va[0]), .i_vb(r_a_vb[0]), .i_iso(r_iso),
        .i_side({r_a_last, r_a_base, r_a_dir[0]}),
        .o_valid(w_d_vld[0]), .o_quot(w_d_q[0]), .o_side(w_side0)
    );
    for (genvar v = 1; v < 3; v++) begin : g_div
        mtc_div_pipe #(
            .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS), .SIDE_W(SD_W)
        ) u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_a_vld),
            .i_va(r_a_va[v]), .i_vb(r_a_vb[v]), .i_iso(r_iso),
            .i_side(r_a_dir[v]),
            .o_valid(w_d_vld[v]), .o_quot(w_d_q[v]), .o_side(w_side12[v-1])
        );
    end

    assign w_d_dir  = {w_side12[1], w_side12[0], w_side0[SD_W-1:0]};
    assign w_d_base = w_side0[SD_W +: 3*GRID_BITS];

    // Coordinates: corner position plus or minus t along each axis.
    always_comb begin
        logic [OW-1:0] pos;
        logic          da;
        logic          db;
        for (int v = 0; v < 3; v++) begin
            for (int a = 0; a < 3; a++) begin
                da  = w_d_dir[v][a];
                db  = w_d_dir[v][3 + a];
                pos = (OW'(w_d_base[a*GRID_BITS +: GRID_BITS]) + OW'(da)) << FRAC_BITS;
                if (db && !da) begin
                    pos = pos + OW'(w_d_q[v]);
                end else if (da && !db) begin
                    pos = pos - OW'(w_d_q[v]);
                end
                n_out[(3*v + a)*OW +: OW] = pos;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_d_vld[0];
        end
        if (w_en) begin
            r_out      <= n_out;
            r_out_last <= w_side0[S0_W-1];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_TW'(r_out);
    assign o_m_tlast  = r_out_last;

    // The three vertex lanes always run in lockstep.
    `MTC_ASSERT_IMPLIES(a_lanes_lockstep, w_d_vld[0], (w_d_vld[1] && w_d_vld[2]))
    // Pending slots hold while the pipeline is stalled.
    `MTC_ASSERT_NEXT(a_slots_hold, (r_slots != '0 && !w_en), (r_slots == $past(r_slots)))
    // A taken cell with crossings leaves pending work.
    `MTC_ASSERT_NEXT(a_cell_loaded, (w_s_acc && w_in_slots != '0), (r_slots != '0))

endmodule

// ===== src/mtc_tetra_lane.sv =====
// One tetrahedron lane: inside mask of its four corners and its triangle slots.
// Depends on mtc_pkg.
module mtc_tetra_lane #(
    parameter int SAMPLE_BITS = mtc_pkg::SAMPLE_BITS_DEF
) (
    input  logic [3:0][SAMPLE_BITS-1:0] i_samp,
    input  logic [SAMPLE_BITS-1:0]      i_iso,
    output mtc_pkg::t_mask              o_mask,
    output logic [1:0]                  o_slots
);

    logic [1:0] w_count;

    // A corner below the threshold counts as inside.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_mask[i] = i_samp[i] < i_iso;
        end
    end

    // Slot bit 0 is the first triangle, bit 1 the second.
    assign w_count = mtc_pkg::case_count(o_mask);
    assign o_slots = {w_count == 2'd2, w_count != 2'd0};

endmodule

// ===== src/mtc_div_pipe.sv =====
// Pipelined restoring divider for one vertex lane: t = (|iso-va| << F) / |vb-va|.
// One quotient bit per stage, sideband carried alongside. Depends on mtc_pkg.
module mtc_div_pipe #(
    parameter int SAMPLE_BITS = mtc_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = mtc_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W      = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_va,
    input  logic [SAMPLE_BITS-1:0] i_vb,
    input  logic [SAMPLE_BITS-1:0] i_iso,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [FRAC_BITS:0]     o_quot,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int NST = FRAC_BITS + 2;
    localparam int RW  = SAMPLE_BITS + 1;

    logic [NST-1:0]             r_vld;
    logic [RW-1:0]              r_rem  [NST];
    logic [SAMPLE_BITS-1:0]     r_den  [NST];
    logic [FRAC_BITS:0]         r_q    [NST];
    logic [NST-1:0]             r_dz;
    logic [SIDE_W-1:0]          r_side [NST];
    logic [SAMPLE_BITS-1:0]     n_num;
    logic [SAMPLE_BITS-1:0]     n_den;

    // Entry stage: absolute differences.
    assign n_num = (i_iso >= i_va) ? i_iso - i_va : i_va - i_iso;
    assign n_den = (i_vb >= i_va) ? i_vb - i_va : i_va - i_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= RW'(n_num);
            r_den[0]  <= n_den;
            r_q[0]    <= '0;
            r_dz[0]   <= n_den == '0;
            r_side[0] <= i_side;
        end
    end

    // Quotient stages, most significant bit first.
    for (genvar j = 1; j < NST; j++) begin : g_stage
        logic [RW-1:0] w_part;
        logic          w_ge;
        if (j == 1) begin : g_first
            assign w_part = r_rem[j-1];
        end else begin : g_shift
            assign w_part = {r_rem[j-1][RW-2:0], 1'b0};
        end
        assign w_ge = w_part >= RW'(r_den[j-1]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= r_vld[j-1];
            end
            if (i_en) begin
                r_rem[j]  <= w_ge ? w_part - RW'(r_den[j-1]) : w_part;
                r_den[j]  <= r_den[j-1];
                r_q[j]    <= {r_q[j-1][FRAC_BITS-1:0], w_ge};
                r_dz[j]   <= r_dz[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // A zero span means no interpolation.
    assign o_valid = r_vld[NST-1];
    assign o_quot  = r_dz[NST-1] ? '0 : r_q[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

// ===== sim/mtc_checker.sv =====
// Checker for the marching tetrahedra cell: watches both streams, predicts
// the triangles of every accepted cell and compares them. Depends on nothing.
`timescale 1ns / 100ps
module mtc_checker #(
    parameter int IN_TW  = 160,
    parameter int OUT_TW = 168
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [IN_TW-1:0]  i_s_tdata,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [OUT_TW-1:0] i_m_tdata,
    input  logic              i_m_tlast,
    output int                o_errors,
    output int                o_pending
);
    localparam int GB = 10;
    localparam int FB = 8;
    localparam int OW = GB + FB;

    typedef struct packed {
        logic          last;
        logic [161:0]  verts;
    } tri_t;

    tri_t       triangles_due[$];
    logic [15:0] iso;

    // Corner list of each tetrahedron, visited in this order.
    function automatic int corner_of(int k, int i);
        int tab[6][4] = '{'{0, 7, 3, 2}, '{0, 7, 2, 6}, '{0, 4, 7, 6},
                          '{0, 1, 6, 2}, '{0, 4, 6, 1}, '{5, 1, 6, 4}};
        return tab[k][i];
    endfunction

    // Edges per case as {local a, local b} nibbles, triangle-major.
    function automatic int edge_of(int m, int t, int v);
        int e[16][2][3] = '{
            '{'{0, 0, 0}, '{0, 0, 0}},
            '{'{1, 3, 2}, '{0, 0, 0}},
            '{'{4, 6, 7}, '{0, 0, 0}},
            '{'{12, 8, 7}, '{8, 9, 7}},
            '{'{8, 11, 9}, '{0, 0, 0}},
            '{'{12, 6, 4}, '{6, 12, 11}},
            '{'{1, 2, 7}, '{7, 2, 14}},
            '{'{12, 14, 13}, '{0, 0, 0}},
            '{'{13, 14, 12}, '{0, 0, 0}},
            '{'{1, 7, 2}, '{7, 14, 2}},
            '{'{12, 4, 6}, '{6, 11, 12}},
            '{'{9, 11, 8}, '{0, 0, 0}},
            '{'{7, 8, 12}, '{8, 7, 9}},
            '{'{4, 7, 6}, '{0, 0, 0}},
            '{'{1, 2, 3}, '{0, 0, 0}},
            '{'{0, 0, 0}, '{0, 0, 0}}};
        return e[m][t][v];
    endfunction

    function automatic logic [OW-1:0] axis_pos(logic [GB-1:0] b, int da, int db,
                                               logic [31:0] t);
        logic [OW+1:0] v;
        v = (OW+2)'(b + da) << FB;
        if (db > da) v = v + t;
        else if (db < da) v = v - t;
        return v[OW-1:0];
    endfunction

    // Predict all triangles of one cell and queue them.
    task automatic predict_cell(logic [IN_TW-1:0] d);
        logic [GB-1:0] b[3];
        logic [15:0]   s[8];
        logic [161:0]  vs;
        logic [31:0]   num, den, t;
        int m, nt, ca, cb, e, first;
        tri_t tr;
        first = triangles_due.size();
        for (int a = 0; a < 3; a++) b[a] = d[a*GB +: GB];
        for (int i = 0; i < 8; i++) s[i] = d[3*GB + 16*i +: 16];
        for (int k = 0; k < 6; k++) begin
            m = 0;
            for (int i = 0; i < 4; i++)
                if (s[corner_of(k, i)] < iso) m |= 1 << i;
            nt = (m == 0 || m == 15) ? 0 : ($countones(m) == 2 ? 2 : 1);
            for (int tt = 0; tt < nt; tt++) begin
                for (int v = 0; v < 3; v++) begin
                    e = edge_of(m, tt, v);
                    ca = corner_of(k, e >> 2);
                    cb = corner_of(k, e & 3);
                    num = iso >= s[ca] ? iso - s[ca] : s[ca] - iso;
                    den = s[cb] >= s[ca] ? s[cb] - s[ca] : s[ca] - s[cb];
                    t = den == 0 ? 0 : (num << FB) / den;
                    vs[(3*v+0)*OW +: OW] = axis_pos(b[0], (ca ^ (ca >> 1)) & 1,
                                                    (cb ^ (cb >> 1)) & 1, t);
                    vs[(3*v+1)*OW +: OW] = axis_pos(b[1], (ca >> 1) & 1,
                                                    (cb >> 1) & 1, t);
                    vs[(3*v+2)*OW +: OW] = axis_pos(b[2], (ca >> 2) & 1,
                                                    (cb >> 2) & 1, t);
                end
                tr.verts = vs;
                tr.last = 1'b0;
                triangles_due.push_back(tr);
            end
        end
        if (triangles_due.size() > first)
            triangles_due[triangles_due.size()-1].last = 1'b1;
    endtask

    assign o_pending = triangles_due.size();

    // Track the threshold, predict every accepted cell and check every triangle.
    always @(posedge i_clk) begin
        tri_t want;
        if (!i_rst_n) begin
            iso <= '0;
            o_errors <= 0;
        end else begin
            if (i_cfg_wr_en) iso <= i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) predict_cell(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (triangles_due.size() == 0) begin
                    $display("%0t: unexpected triangle %h last %b", $time,
                             i_m_tdata[161:0], i_m_tlast);
                    o_errors <= o_errors + 1;
                end else begin
                    want = triangles_due.pop_front();
                    if (want.verts !== i_m_tdata[161:0] || want.last !== i_m_tlast) begin
                        $display("%0t: expected %h last %b, actual %h last %b",
                                 $time, want.verts, want.last,
                                 i_m_tdata[161:0], i_m_tlast);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/tb_marching_tetrahedra_cell.sv =====
// Testbench top for the marching tetrahedra cell: clock, reset, cell stimulus
// and the verdict. Depends on marching_tetrahedra_cell and mtc_checker.
`timescale 1ns / 100ps
module tb_marching_tetrahedra_cell;
    localparam int IN_TW  = 160;
    localparam int OUT_TW = 168;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_wr_en = 0;
    logic [15:0]       i_cfg_wr_data = '0;
    logic              i_s_tvalid = 0;
    logic              o_s_tready;
    logic [IN_TW-1:0]  i_s_tdata = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 0;
    logic [OUT_TW-1:0] o_m_tdata;
    logic              o_m_tlast;
    int                errors, pending;
    int                send_idle = 0, recv_idle = 0;
    bit                hold_off = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    marching_tetrahedra_cell DUT (.*);

    mtc_checker #(.IN_TW(IN_TW), .OUT_TW(OUT_TW)) u_checker (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_wr_data, .i_s_tvalid,
        .i_s_tready(o_s_tready), .i_s_tdata, .i_m_tvalid(o_m_tvalid), .i_m_tready,
        .i_m_tdata(o_m_tdata), .i_m_tlast(o_m_tlast), .o_errors(errors),
        .o_pending(pending));

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(posedge i_clk) begin
        i_m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // Send one cell; the sender may idle before offering it. Valid stays
    // high after the transaction so cells can follow back to back.
    task automatic send_cell(logic [IN_TW-1:0] d);
        if ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    function automatic logic [IN_TW-1:0] make_cell(logic [9:0] x, y, z,
                                                   logic [127:0] s);
        return {2'b0, s, z, y, x};
    endfunction

    // Random cell: most samples near the threshold, the rest random.
    function automatic logic [IN_TW-1:0] rand_cell(logic [15:0] lvl);
        logic [127:0] s;
        int r;
        for (int i = 0; i < 8; i++) begin
            r = $urandom_range(3);
            if (r == 0) s[16*i +: 16] = 16'($urandom);
            else s[16*i +: 16] = 16'(lvl + $urandom_range(600) - 300);
        end
        return make_cell(10'($urandom), 10'($urandom), 10'($urandom), s);
    endfunction

    // Stop offering cells and wait until every predicted triangle has come out.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_level(logic [15:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [15:0] levels[4] = '{16'h8000, 16'hFFFF, 16'h0001, 16'h1234};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // With the threshold at zero nothing is inside: no triangles.
        send_cell(make_cell(10'h3FF, 10'h3FF, 10'h3FF, '0));
        drain();
        set_level(16'h8000);
        // Directed cells: single corners inside, extremes, top of the grid; then random cells.
        for (int c = 0; c < 8; c++)
            send_cell(make_cell(10'h3FF, 10'd0, 10'h155,
                                {8{16'hFFFF}} & ~(128'hFFFF << 16*c)));
        send_cell(make_cell(10'd0, 10'h3FF, 10'h2AA, {4{16'h0000, 16'hFFFF}}));
        send_cell(make_cell(10'h3FF, 10'h3FF, 10'h3FF, {4{16'hFFFF, 16'h0000}}));
        send_cell(make_cell(10'd1, 10'd2, 10'd3, {8{16'h0000}}));
        send_cell(make_cell(10'd1, 10'd2, 10'd3, {8{16'hFFFF}}));
        send_cell(make_cell(10'd5, 10'd6, 10'd7,
                            {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                             16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}));
        for (int m = 0; m < 8; m++)
            send_cell(make_cell(10'($urandom), 10'($urandom), 10'($urandom),
                                {$urandom, $urandom, $urandom, $urandom}));
        drain();
        // Random phases over several thresholds and idling patterns.
        for (int ph = 0; ph < 4; ph++) begin
            set_level(levels[ph]);
            send_idle = (ph == 0) ? 37 : (ph == 1) ? 74 : 0;
            recv_idle = (ph == 0) ? 74 : (ph == 1) ? 37 : 0;
            if (ph == 3) hold_off = 1;
            for (int n = 0; n < 50; n++) send_cell(rand_cell(levels[ph]));
            drain();
        end
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    // Long receiver hold-off while the sender keeps offering cells.
    initial begin
        wait (hold_off);
        repeat (400) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end
endmodule
